// ===== sv/trc_pkg.sv =====
// Shared types, codes and helpers of the TFTP read client.
// No dependencies; every other file imports this package.
package trc_pkg;

    typedef logic [1:0] t_event;
    localparam t_event EV_START  = 2'd0;
    localparam t_event EV_PACKET = 2'd1;
    localparam t_event EV_TICK   = 2'd2;

    typedef logic [1:0] t_send;
    localparam t_send SEND_NONE = 2'd0;
    localparam t_send SEND_RRQ  = 2'd1;
    localparam t_send SEND_ACK  = 2'd2;

    localparam logic [15:0] OP_DATA  = 16'd3;
    localparam logic [15:0] OP_ERROR = 16'd5;
    localparam logic [15:0] OP_OACK  = 16'd6;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_BLOCK_SIZE  = 2'd0;
    localparam t_cfg_idx CFG_RETRY_LIMIT = 2'd1;
    localparam t_cfg_idx CFG_TIMEOUT_MS  = 2'd2;

    localparam logic [15:0] RST_BLOCK_SIZE  = 16'd512;
    localparam logic [7:0]  RST_RETRY_LIMIT = 8'd5;
    localparam logic [15:0] RST_TIMEOUT_MS  = 16'd1000;

    localparam logic [15:0] PORT_FIRST  = 16'd1024;
    localparam logic [15:0] PORT_LAST   = 16'hFFFF;
    localparam logic [15:0] TICKS_MAX   = 16'hFFFF;
    localparam logic [15:0] DATA_HDR_LEN = 16'd4;

    typedef struct packed {
        t_event      event_req;
        logic [15:0] pkt_opcode;
        logic [15:0] pkt_block;
        logic [15:0] pkt_length;
        logic        option_text_match;
        logic [15:0] src_port;
    } t_req;

    typedef struct packed {
        t_send       send_kind;
        logic [15:0] ack_block;
        logic [2:0]  link_state;
        logic [15:0] accepted_bytes;
        logic [31:0] total_bytes;
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic        release_port;
    } t_rsp;

    // OACK length: opcode(2) + "blksize\0"(8) + digits + NUL(1)
    function automatic logic [15:0] oack_length(input logic [15:0] bs);
        logic [15:0] digits;
        begin
            if (bs < 16'd10) begin
                digits = 16'd1;
            end else if (bs < 16'd100) begin
                digits = 16'd2;
            end else if (bs < 16'd1000) begin
                digits = 16'd3;
            end else if (bs < 16'd10000) begin
                digits = 16'd4;
            end else begin
                digits = 16'd5;
            end
            return 16'd11 + digits;
        end
    endfunction

endpackage

// ===== sv/trc_if.sv =====
// Valid/ready channel interfaces for the TFTP read client.
// Depends on trc_pkg for the payload structs.
interface trc_req_if;
    import trc_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface trc_rsp_if;
    import trc_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/trc_in_stage.sv =====
// Input register of the TFTP read client: holds one accepted item.
// Depends on trc_pkg and trc_req_if.
module trc_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    trc_req_if.sink        i_req,
    input  logic           i_take,
    output logic           o_valid,
    output trc_pkg::t_req  o_req
);
    import trc_pkg::*;

    logic r_valid;
    t_req r_req;

    // free when empty or when the held item moves on this cycle
    assign i_req.ready = !r_valid || i_take;
    assign o_valid     = r_valid;
    assign o_req       = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_req <= i_req.payload;
        end
    end

endmodule

// ===== sv/trc_engine.sv =====
// Protocol state, config registers and result register of the TFTP read client.
// Depends on trc_pkg and trc_rsp_if.
module trc_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  trc_pkg::t_cfg_idx i_cfg_idx,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_in_valid,
    input  trc_pkg::t_req     i_in_req,
    output logic              o_take,
    trc_rsp_if.source         o_rsp
);
    import trc_pkg::*;

    typedef enum logic [2:0] {
        LS_IDLE = 3'd0,
        LS_INIT = 3'd1,
        LS_XFER = 3'd2,
        LS_DONE = 3'd3,
        LS_ERR  = 3'd4
    } t_link;

    logic [15:0] r_block_size;
    logic [7:0]  r_retry_limit;
    logic [15:0] r_timeout_ms;

    t_link       r_state,     n_state;
    logic [15:0] r_exp_block, n_exp_block;
    logic [7:0]  r_retries,   n_retries;
    logic [15:0] r_elapsed,   n_elapsed;
    logic [31:0] r_bytes,     n_bytes;
    logic [15:0] r_next_port, n_next_port;
    logic [15:0] r_cur_port,  n_cur_port;
    logic [15:0] r_srv_port,  n_srv_port;
    logic        r_out_valid;
    t_rsp        r_rsp,       n_rsp;

    logic        busy;
    logic [15:0] nxt_block;
    logic [15:0] data_len;
    logic [15:0] tick_count;
    t_send       send;
    logic [15:0] accepted;
    logic        rel;

    assign o_take        = i_in_valid && (!r_out_valid || o_rsp.ready);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_rsp;

    assign busy       = (r_state == LS_INIT) || (r_state == LS_XFER);
    assign nxt_block  = r_exp_block + 16'd1;
    assign data_len   = (i_in_req.pkt_length >= DATA_HDR_LEN) ?
                        (i_in_req.pkt_length - DATA_HDR_LEN) : 16'd0;
    assign tick_count = (r_elapsed < TICKS_MAX) ? (r_elapsed + 16'd1) : r_elapsed;

    always_comb begin
        n_state     = r_state;
        n_exp_block = r_exp_block;
        n_retries   = r_retries;
        n_elapsed   = r_elapsed;
        n_bytes     = r_bytes;
        n_next_port = r_next_port;
        n_cur_port  = r_cur_port;
        n_srv_port  = r_srv_port;
        send        = SEND_NONE;
        accepted    = 16'd0;
        rel         = 1'b0;

        if (i_in_req.event_req == EV_START) begin
            n_cur_port  = r_next_port;
            n_next_port = (r_next_port == PORT_LAST) ? PORT_FIRST : (r_next_port + 16'd1);
            n_bytes     = 32'd0;
            n_state     = LS_INIT;
            n_elapsed   = 16'd0;
            n_retries   = r_retry_limit;
            send        = SEND_RRQ;
        end else if (i_in_req.event_req == EV_PACKET && busy) begin
            if (i_in_req.pkt_opcode == OP_ERROR) begin
                n_state = LS_ERR;
                rel     = 1'b1;
            end else if (r_state == LS_INIT) begin
                if (i_in_req.pkt_opcode == OP_OACK) begin
                    if (i_in_req.pkt_length == oack_length(r_block_size) &&
                        i_in_req.option_text_match) begin
                        n_srv_port  = i_in_req.src_port;
                        n_exp_block = 16'd0;
                        send        = SEND_ACK;
                        n_elapsed   = 16'd0;
                        n_retries   = r_retry_limit;
                        n_state     = LS_XFER;
                    end else begin
                        n_state = LS_ERR;
                        rel     = 1'b1;
                    end
                end else if (i_in_req.pkt_opcode == OP_DATA) begin
                    // server ignored the option
                    n_state = LS_ERR;
                    rel     = 1'b1;
                end
            end else if (i_in_req.pkt_opcode == OP_DATA &&
                         i_in_req.pkt_block == nxt_block) begin
                n_exp_block = nxt_block;
                accepted    = data_len;
                n_bytes     = r_bytes + {16'd0, data_len};
                send        = SEND_ACK;
                n_elapsed   = 16'd0;
                n_retries   = r_retry_limit;
                if (data_len < r_block_size) begin
                    n_state = LS_DONE;
                    rel     = 1'b1;
                end
            end
        end else if (i_in_req.event_req == EV_TICK && busy) begin
            n_elapsed = tick_count;
            if (tick_count >= r_timeout_ms) begin
                if (r_retries != 8'd0) begin
                    send      = (r_state == LS_INIT) ? SEND_RRQ : SEND_ACK;
                    n_elapsed = 16'd0;
                    n_retries = r_retries - 8'd1;
                end else begin
                    n_state = LS_ERR;
                    rel     = 1'b1;
                end
            end
        end

        n_rsp.send_kind      = send;
        n_rsp.ack_block      = (send == SEND_ACK) ? n_exp_block : 16'd0;
        n_rsp.link_state     = n_state;
        n_rsp.accepted_bytes = accepted;
        n_rsp.total_bytes    = n_bytes;
        n_rsp.local_port     = n_cur_port;
        n_rsp.remote_port    = n_srv_port;
        n_rsp.release_port   = rel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size  <= RST_BLOCK_SIZE;
            r_retry_limit <= RST_RETRY_LIMIT;
            r_timeout_ms  <= RST_TIMEOUT_MS;
            r_state       <= LS_IDLE;
            r_exp_block   <= 16'd0;
            r_retries     <= 8'd0;
            r_elapsed     <= 16'd0;
            r_bytes       <= 32'd0;
            r_next_port   <= PORT_FIRST;
            r_cur_port    <= PORT_FIRST;
            r_srv_port    <= 16'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BLOCK_SIZE:  r_block_size  <= i_cfg_wdata;
                    CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_wdata[7:0];
                    CFG_TIMEOUT_MS:  r_timeout_ms  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (o_take) begin
                r_state     <= n_state;
                r_exp_block <= n_exp_block;
                r_retries   <= n_retries;
                r_elapsed   <= n_elapsed;
                r_bytes     <= n_bytes;
                r_next_port <= n_next_port;
                r_cur_port  <= n_cur_port;
                r_srv_port  <= n_srv_port;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_rsp <= n_rsp;
        end
    end

    // a release only comes with a closing state
    a_release_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rsp.release_port) |->
        (r_rsp.link_state == LS_DONE || r_rsp.link_state == LS_ERR))
        else $error("release without finished/error state");

    // counted bytes are always acknowledged
    a_bytes_acked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rsp.accepted_bytes != 16'd0) |-> (r_rsp.send_kind == SEND_ACK))
        else $error("data counted without acknowledge");

    // the result shows the state that was stored with it
    a_state_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> (r_rsp.link_state == r_state && r_rsp.total_bytes == r_bytes))
        else $error("result state differs from stored state");

    // port allocator stays in the ephemeral range
    a_port_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_port >= PORT_FIRST && r_cur_port >= PORT_FIRST))
        else $error("local port below first ephemeral port");

endmodule

// ===== sv/tftp_read_client.sv =====
// Top level of the TFTP read client (read request with block-size option).
// Depends on trc_pkg, trc_if, trc_in_stage and trc_engine.

// The client takes one item per clock: a start request, a received packet
// (opcode, block number, length, option-text check, source port) or a
// millisecond tick, and returns exactly one result item for each. An item
// passes through the input register, then the state update that loads the
// result register; a result is valid once its item has left the input
// register, and a new item can enter every cycle as long as results are
// taken. While a result waits, the item behind it stays in the input register
// and input ready drops until the result is taken; input ready follows output
// ready combinationally through that path. Config registers
// (0 block_size, 1 retry_limit, 2 timeout_ms) are written through
// i_cfg_we/i_cfg_idx/i_cfg_wdata and must only be changed while the client
// has no item in flight; block_size is used live. Indexes beyond the list are
// ignored. Local ports count from 1024 up to 65535 and wrap back to 1024;
// the byte total wraps at 2^32.
module tftp_read_client (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  trc_pkg::t_cfg_idx i_cfg_idx,
    input  logic [15:0]       i_cfg_wdata,
    trc_req_if.sink           i_req,
    trc_rsp_if.source         o_rsp
);
    import trc_pkg::*;

    logic stage_valid;
    t_req stage_req;
    logic take;

    // input register
    trc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_take  (take),
        .o_valid (stage_valid),
        .o_req   (stage_req)
    );

    // state update and result register
    trc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (stage_valid),
        .i_in_req    (stage_req),
        .o_take      (take),
        .o_rsp       (o_rsp)
    );

endmodule

// ===== sim/trc_chk.sv =====
// Checker for the TFTP read client: watches config writes and both channels,
// predicts one result item per accepted item and compares field by field.
// Depends on trc_pkg for the item structs and codes.
`timescale 1ns / 100ps

module trc_chk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  trc_pkg::t_cfg_idx i_cfg_idx,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  trc_pkg::t_req     i_req_item,
    input  logic              i_rsp_valid,
    input  logic              i_rsp_ready,
    input  trc_pkg::t_rsp     i_rsp_item,
    output int                o_errors,
    output int                o_pending
);
    import trc_pkg::*;

    typedef enum logic [2:0] {
        LS_IDLE = 3'd0,
        LS_INIT = 3'd1,
        LS_XFER = 3'd2,
        LS_DONE = 3'd3,
        LS_ERR  = 3'd4
    } t_link;

    // config copy
    logic [15:0] blk_size_cfg;
    logic [7:0]  retry_cfg;
    logic [15:0] timeout_cfg;

    // client state copy
    t_link       link;
    logic [15:0] want_blk;
    logic [7:0]  retries;
    logic [15:0] ticks;
    logic [31:0] bytes_rx;
    logic [15:0] port_next;
    logic [15:0] port_cur;
    logic [15:0] port_srv;

    t_rsp pending_results[$];

    // opcode, "blksize" and its NUL, value text, NUL
    function automatic logic [15:0] oack_len_for(input logic [15:0] bs);
        logic [15:0] rest;
        logic [15:0] digits;
        rest   = bs;
        digits = 16'd1;
        while (rest >= 16'd10) begin
            rest   = rest / 16'd10;
            digits = digits + 16'd1;
        end
        return 16'd11 + digits;
    endfunction

    task automatic advance_client(input t_req it, output t_rsp res);
        t_send       send;
        logic [15:0] got_bytes;
        logic        freed;
        logic [15:0] blk_inc;
        logic        busy;
        send      = SEND_NONE;
        got_bytes = '0;
        freed     = 1'b0;
        busy      = (link == LS_INIT) || (link == LS_XFER);
        blk_inc   = want_blk + 16'd1;
        case (it.event_req)
            EV_START: begin
                port_cur  = port_next;
                port_next = (port_next == PORT_LAST) ? PORT_FIRST : port_next + 16'd1;
                bytes_rx  = '0;
                link      = LS_INIT;
                ticks     = '0;
                retries   = retry_cfg;
                send      = SEND_RRQ;
            end
            EV_PACKET: begin
                if (busy) begin
                    if (it.pkt_opcode == OP_ERROR) begin
                        link  = LS_ERR;
                        freed = 1'b1;
                    end else if (link == LS_INIT) begin
                        if (it.pkt_opcode == OP_OACK) begin
                            if (it.pkt_length == oack_len_for(blk_size_cfg) &&
                                it.option_text_match) begin
                                port_srv = it.src_port;
                                want_blk = '0;
                                send     = SEND_ACK;
                                ticks    = '0;
                                retries  = retry_cfg;
                                link     = LS_XFER;
                            end else begin
                                link  = LS_ERR;
                                freed = 1'b1;
                            end
                        end else if (it.pkt_opcode == OP_DATA) begin
                            // server ignored the option
                            link  = LS_ERR;
                            freed = 1'b1;
                        end
                    end else if (it.pkt_opcode == OP_DATA && it.pkt_block == blk_inc) begin
                        got_bytes = (it.pkt_length >= DATA_HDR_LEN) ?
                                    it.pkt_length - DATA_HDR_LEN : 16'd0;
                        want_blk  = blk_inc;
                        bytes_rx  = bytes_rx + {16'd0, got_bytes};
                        send      = SEND_ACK;
                        ticks     = '0;
                        retries   = retry_cfg;
                        if (got_bytes < blk_size_cfg) begin
                            link  = LS_DONE;
                            freed = 1'b1;
                        end
                    end
                end
            end
            EV_TICK: begin
                if (busy) begin
                    if (ticks != TICKS_MAX) ticks = ticks + 16'd1;
                    if (ticks >= timeout_cfg) begin
                        if (retries != 8'd0) begin
                            send    = (link == LS_INIT) ? SEND_RRQ : SEND_ACK;
                            ticks   = '0;
                            retries = retries - 8'd1;
                        end else begin
                            link  = LS_ERR;
                            freed = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.send_kind      = send;
        res.ack_block      = (send == SEND_ACK) ? want_blk : 16'd0;
        res.link_state     = link;
        res.accepted_bytes = got_bytes;
        res.total_bytes    = bytes_rx;
        res.local_port     = port_cur;
        res.remote_port    = port_srv;
        res.release_port   = freed;
    endtask

    task automatic cmp(input string field, input logic [31:0] exp, input logic [31:0] act);
        if (exp !== act) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp, act);
            o_errors++;
        end
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin : watch
        t_rsp exp_r;
        if (!i_rst_n) begin
            blk_size_cfg = RST_BLOCK_SIZE;
            retry_cfg    = RST_RETRY_LIMIT;
            timeout_cfg  = RST_TIMEOUT_MS;
            link         = LS_IDLE;
            want_blk     = '0;
            retries      = '0;
            ticks        = '0;
            bytes_rx     = '0;
            port_next    = PORT_FIRST;
            port_cur     = PORT_FIRST;
            port_srv     = '0;
            pending_results.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result item with nothing expected, got %0h",
                             $time, i_rsp_item);
                    o_errors++;
                end else begin
                    exp_r = pending_results.pop_front();
                    cmp("send_kind", 32'(exp_r.send_kind), 32'(i_rsp_item.send_kind));
                    cmp("ack_block", 32'(exp_r.ack_block), 32'(i_rsp_item.ack_block));
                    cmp("link_state", 32'(exp_r.link_state), 32'(i_rsp_item.link_state));
                    cmp("accepted_bytes", 32'(exp_r.accepted_bytes),
                        32'(i_rsp_item.accepted_bytes));
                    cmp("total_bytes", exp_r.total_bytes, i_rsp_item.total_bytes);
                    cmp("local_port", 32'(exp_r.local_port), 32'(i_rsp_item.local_port));
                    cmp("remote_port", 32'(exp_r.remote_port), 32'(i_rsp_item.remote_port));
                    cmp("release_port", 32'(exp_r.release_port),
                        32'(i_rsp_item.release_port));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BLOCK_SIZE:  blk_size_cfg = i_cfg_wdata;
                    CFG_RETRY_LIMIT: retry_cfg    = i_cfg_wdata[7:0];
                    CFG_TIMEOUT_MS:  timeout_cfg  = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                advance_client(i_req_item, exp_r);
                pending_results.push_back(exp_r);
            end
        end
        o_pending = pending_results.size();
    end

endmodule

// ===== sim/tb_tftp_read_client.sv =====
// Top of the TFTP read client testbench: clock, reset, config writes and
// item stimulus with idle and stall patterns; trc_chk does the checking.
// Depends on trc_pkg, trc_if, tftp_read_client and trc_chk.
`timescale 1ns / 100ps

module tb_tftp_read_client;
    import trc_pkg::*;

    // event code the client must ignore
    localparam t_event EV_NONE = 2'd3;
    // opcodes with no meaning to the client
    localparam logic [15:0] OP_ODD_LO = 16'h0000;
    localparam logic [15:0] OP_ODD_HI = 16'hFFFF;

    localparam int HOLD_CYCLES = 300;   // long result stall for back-pressure
    localparam int LONG_BLOCKS = 4;     // full blocks at the largest block size

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    t_cfg_idx    cfg_idx;
    logic [15:0] cfg_wdata;

    int errors;
    int pending;

    // stimulus knobs, changed between phases
    int          idle_pct  = 0;
    int          stall_pct = 0;
    bit          hold_rsp  = 1'b0;
    int          sent      = 0;
    logic [15:0] cur_bs    = RST_BLOCK_SIZE;

    trc_req_if req_ch ();
    trc_rsp_if rsp_ch ();

    tftp_read_client dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    trc_chk chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_req_valid (req_ch.valid),
        .i_req_ready (req_ch.ready),
        .i_req_item  (req_ch.payload),
        .i_rsp_valid (rsp_ch.valid),
        .i_rsp_ready (rsp_ch.ready),
        .i_rsp_item  (rsp_ch.payload),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side. Normally ready drops at random per stall_pct; when the
    // stimulus raises hold_rsp, ready stays low for a long counted stretch
    // so the client fills up and pushes back on its input.
    always begin : rsp_side
        @(posedge clk);
        if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clk);
            hold_rsp = 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    function automatic logic rnd1();
        return 1'($urandom);
    endfunction

    // Received packet with chosen fields.
    function automatic t_req pkt(input logic [15:0] op, input logic [15:0] blk,
                                 input logic [15:0] len, input logic match,
                                 input logic [15:0] sport);
        t_req r;
        r.event_req         = EV_PACKET;
        r.pkt_opcode        = op;
        r.pkt_block         = blk;
        r.pkt_length        = len;
        r.option_text_match = match;
        r.src_port          = sport;
        return r;
    endfunction

    // Start, tick or ignored event; packet fields are don't-care and get junk.
    function automatic t_req ctl(input t_event ev);
        t_req r;
        r.event_req         = ev;
        r.pkt_opcode        = rnd16();
        r.pkt_block         = rnd16();
        r.pkt_length        = rnd16();
        r.option_text_match = rnd1();
        r.src_port          = rnd16();
        return r;
    endfunction

    function automatic t_req noise();
        t_req r;
        r = ctl(EV_START);
        r.event_req = 2'($urandom_range(3));
        return r;
    endfunction

    // Offer one item; returns at the edge where it was taken. Ready is
    // sampled at the falling edge, when it has settled.
    task automatic offer(input t_req it);
        bit took;
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= it;
        do begin
            @(negedge clk);
            took = (req_ch.ready === 1'b1);
            @(posedge clk);
        end while (!took);
        sent++;
    endtask

    // Stop offering and wait until every predicted result has been taken.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (4) @(posedge clk);
    endtask

    // Back-to-back writes keep the enable high across all three registers.
    task automatic set_config(input logic [15:0] bs, input logic [7:0] rl,
                              input logic [15:0] to);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_BLOCK_SIZE;
        cfg_wdata <= bs;
        @(posedge clk);
        cfg_idx   <= CFG_RETRY_LIMIT;
        cfg_wdata <= {8'd0, rl};
        @(posedge clk);
        cfg_idx   <= CFG_TIMEOUT_MS;
        cfg_wdata <= to;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_bs     = bs;
    endtask

    // Mostly well-formed sessions (start, option ack, numbered data blocks,
    // closing short block) with random content, mixed with ticks, duplicates,
    // stray opcodes, error packets and junk items.
    task automatic random_traffic(input int count);
        int          stop_at;
        int          pick;
        int          n_blk;
        logic [15:0] nb;
        logic [15:0] len;
        stop_at = sent + count;
        while (sent < stop_at) begin
            offer(ctl(EV_START));
            if ($urandom_range(4) == 0) repeat ($urandom_range(4, 1)) offer(ctl(EV_TICK));
            pick = $urandom_range(19);
            case (pick)
                0: offer(pkt(OP_OACK, rnd16(), rnd16(), rnd1(), rnd16()));
                1: offer(pkt(OP_OACK, rnd16(), oack_length(cur_bs), 1'b0, rnd16()));
                2: offer(pkt(OP_DATA, 16'd1, cur_bs + 16'd4, rnd1(), rnd16()));
                3: offer(pkt(OP_ERROR, rnd16(), rnd16(), rnd1(), rnd16()));
                4: offer(noise());
                default: offer(pkt(OP_OACK, rnd16(), oack_length(cur_bs), 1'b1, rnd16()));
            endcase
            nb    = 16'd1;
            n_blk = $urandom_range(12);
            repeat (n_blk) begin
                pick = $urandom_range(99);
                if (pick < 62) begin
                    // full block, now and then longer than needed
                    len = ($urandom_range(3) == 0) ?
                          16'($urandom_range(65535, 32'(cur_bs) + 4)) :
                          cur_bs + 16'd4;
                    offer(pkt(OP_DATA, nb, len, rnd1(), rnd16()));
                    nb = nb + 16'd1;
                end else if (pick < 68) begin
                    offer(pkt(OP_DATA, nb - 16'd1, cur_bs + 16'd4, rnd1(), rnd16()));
                end else if (pick < 72) begin
                    offer(pkt(OP_DATA, rnd16(), rnd16(), rnd1(), rnd16()));
                end else if (pick < 84) begin
                    repeat ($urandom_range(4, 1)) offer(ctl(EV_TICK));
                end else if (pick < 90) begin
                    offer(noise());
                end else if (pick < 95) begin
                    offer(pkt(rnd16(), rnd16(), rnd16(), rnd1(), rnd16()));
                end else if (pick < 97) begin
                    offer(pkt(OP_ERROR, rnd16(), rnd16(), rnd1(), rnd16()));
                end else begin
                    offer(pkt(OP_OACK, rnd16(), oack_length(cur_bs), 1'b1, rnd16()));
                end
            end
            // most sessions close with a short block, some are abandoned
            if ($urandom_range(4) != 0) begin
                len = ($urandom_range(7) == 0) ? 16'($urandom_range(3)) :
                      16'($urandom_range(32'(cur_bs) + 3));
                offer(pkt(OP_DATA, nb, len, rnd1(), rnd16()));
            end
        end
    endtask

    initial begin : stim
        logic [15:0] bs_list [12] = '{16'd8, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999,
                                      16'd1000, 16'd9999, 16'd10000, 16'd65464, 16'd0,
                                      16'd512};
        logic [7:0]  rl_list [12] = '{8'd0, 8'd1, 8'd255, 8'd2, 8'd3, 8'd0,
                                      8'd1, 8'd255, 8'd2, 8'd1, 8'd0, 8'd5};
        logic [15:0] to_list [12] = '{16'd0, 16'd1, 16'd0, 16'd3, 16'd2, 16'd1,
                                      16'd2, 16'd1, 16'd4, 16'd3, 16'd0, 16'd1000};
        int          ph;
        logic [15:0] nb;

        // every input known from time zero
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= CFG_BLOCK_SIZE;
        cfg_wdata      <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        rsp_ch.ready   <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset config: block size 512, option ack length 14.
        offer(pkt(OP_DATA, 16'd1, 16'd516, 1'b1, 16'd69));  // packet while idle
        offer(ctl(EV_TICK));                                 // tick while idle
        offer(ctl(EV_NONE));                                 // unknown event
        offer(ctl(EV_START));
        offer(pkt(OP_DATA, 16'd1, 16'd516, 1'b1, 16'd69));  // data in init: refused
        offer(pkt(OP_OACK, 16'd0, 16'd14, 1'b1, 16'd69));   // ignored in error
        offer(ctl(EV_START));
        offer(pkt(OP_OACK, 16'd0, 16'd15, 1'b1, 16'd69));   // wrong option length
        offer(ctl(EV_START));
        offer(pkt(OP_OACK, 16'd0, 16'd14, 1'b0, 16'd69));   // option text mismatch
        offer(ctl(EV_START));
        offer(pkt(OP_OACK, 16'd0, 16'd14, 1'b1, 16'hFFFF)); // good: transfer, ACK 0
        offer(pkt(OP_ODD_LO, 16'd1, 16'd516, 1'b1, 16'd0)); // stray opcodes ignored
        offer(pkt(OP_ODD_HI, 16'd1, 16'd516, 1'b1, 16'd0));
        offer(pkt(OP_DATA, 16'd2, 16'd516, 1'b1, 16'd0));   // block skipped ahead
        offer(pkt(OP_DATA, 16'd1, 16'd516, 1'b1, 16'd0));   // full block
        offer(pkt(OP_DATA, 16'd1, 16'd516, 1'b1, 16'd0));   // duplicate, no ACK
        offer(pkt(OP_DATA, 16'd2, 16'd3, 1'b1, 16'd0));     // below header: 0 bytes, done
        offer(ctl(EV_START));
        offer(pkt(OP_OACK, 16'd0, 16'd14, 1'b1, 16'd0));
        offer(pkt(OP_DATA, 16'd1, 16'hFFFF, 1'b0, 16'd0));  // largest block
        offer(ctl(EV_START));                                // restart while busy
        offer(pkt(OP_ERROR, 16'd0, 16'd0, 1'b0, 16'd0));    // error in init
        offer(ctl(EV_START));
        offer(pkt(OP_OACK, 16'd0, 16'd14, 1'b1, 16'd0));
        offer(pkt(OP_ERROR, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF)); // error in transfer
        drain();

        // A short transfer at the largest block size with the longest data
        // blocks, closed by a short block. Then a timeout with no retries
        // left ends in error on the last tick.
        set_config(16'd65464, 8'd0, 16'd3);
        offer(ctl(EV_START));
        offer(pkt(OP_OACK, 16'd0, oack_length(cur_bs), 1'b1, rnd16()));
        nb = 16'd1;
        repeat (LONG_BLOCKS) begin
            offer(pkt(OP_DATA, nb, 16'hFFFF, rnd1(), rnd16()));
            nb = nb + 16'd1;
        end
        offer(pkt(OP_DATA, nb, 16'd100, rnd1(), rnd16()));
        offer(ctl(EV_START));
        repeat (3) offer(ctl(EV_TICK));
        drain();

        // Back-pressure: results held off while items keep coming.
        set_config(16'd100, 8'd3, 16'd2);
        hold_rsp = 1'b1;
        random_traffic(60);
        drain();

        // Random phases over a spread of settings and idle patterns.
        for (ph = 0; ph < 12; ph++) begin
            if (ph == 10) begin
                bs_list[ph] = 16'($urandom_range(65464, 8));
                rl_list[ph] = 8'($urandom_range(255));
                to_list[ph] = 16'($urandom_range(6));
            end
            set_config(bs_list[ph], rl_list[ph], to_list[ph]);
            case (ph % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 68;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 68;
                end
                default: begin
                    idle_pct  = 16;
                    stall_pct = 16;
                end
            endcase
            random_traffic(105);
            drain();
        end

        // all results in; let a few more cycles pass for anything stray
        stall_pct = 0;
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin : watchdog
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
